>>> src/tacf_pkg.sv
// Package with shared types, constants and tables for the tilt-angle fusion block.
package tacf_pkg;

   localparam int DefCordicSteps   = 16;
   localparam int DefAngleFracBits = 16;

   localparam int SampleWidth = 16;
   localparam int AngleWidth  = 25;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 24;

   localparam logic [CsrIdxWidth-1:0] CSR_BLEND_GAIN  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_TIME_STEP   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_GYRO_SCALE  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TILT_B_POS  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_TILT_B_NEG  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_TILT_A_POS  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_TILT_A_NEG  = 3'd6;

   localparam logic [16:0] RST_BLEND_GAIN = 17'd32768;
   localparam logic [23:0] RST_TIME_STEP  = 24'd90597;
   localparam logic [15:0] RST_GYRO_SCALE = 16'd4000;
   localparam logic [23:0] RST_TILT_B_POS = 24'd5891686;
   localparam logic [23:0] RST_TILT_B_NEG = 24'd5904794;
   localparam logic [23:0] RST_TILT_A_POS = 24'd5714739;
   localparam logic [23:0] RST_TILT_A_NEG = 24'd6081741;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CORDIC,
      ST_TILT,
      ST_MUL_RATE,
      ST_MUL_S,
      ST_MUL_H,
      ST_MUL_L,
      ST_FUSE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } ctl_type;

   function automatic logic [31:0] atan_q24(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'd754974720;
         5'd1:  r = 32'd445687602;
         5'd2:  r = 32'd235489089;
         5'd3:  r = 32'd119537938;
         5'd4:  r = 32'd60000934;
         5'd5:  r = 32'd30029717;
         5'd6:  r = 32'd15018523;
         5'd7:  r = 32'd7509720;
         5'd8:  r = 32'd3754917;
         5'd9:  r = 32'd1877466;
         5'd10: r = 32'd938734;
         5'd11: r = 32'd469367;
         5'd12: r = 32'd234684;
         5'd13: r = 32'd117342;
         5'd14: r = 32'd58671;
         5'd15: r = 32'd29335;
         5'd16: r = 32'd14668;
         5'd17: r = 32'd7334;
         5'd18: r = 32'd3667;
         5'd19: r = 32'd1833;
         5'd20: r = 32'd917;
         5'd21: r = 32'd458;
         5'd22: r = 32'd229;
         5'd23: r = 32'd115;
         5'd24: r = 32'd57;
         5'd25: r = 32'd29;
         5'd26: r = 32'd14;
         5'd27: r = 32'd7;
         5'd28: r = 32'd4;
         5'd29: r = 32'd2;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> src/tilt_angle_complementary_fusion.sv
// Top level of the tilt-angle complementary fusion block.
// Each item passes through the bit-serial square root and the CORDIC iterations of
// the shared tilt unit, which runs for the Y tilt and then the X tilt, and through
// the shared fusion multiplier, which runs for the X and then the Y angle. The block
// takes no new item until the result has been delivered. Configuration writes are
// taken at any time.
module tilt_angle_complementary_fusion
   import tacf_pkg::*;
#(
   parameter int CORDIC_STEPS    = DefCordicSteps
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_rate[63:48]
   input  logic [63:0]             req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // fused_angle_x[24:0], fused_angle_y[49:25], tilt_a[74:50], tilt_b[99:75], zeros
   output logic [103:0]            rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   state_type st_ff, st_in;
   logic [63:0] in_ff, in_in;
   logic signed [AngleWidth-1:0] ax_ff, ay_ff, ta_ff, tb_ff;
   logic [16:0] gain_ff;
   logic [23:0] dt_ff, bpos_ff, bneg_ff, apos_ff, aneg_ff;
   logic [15:0] gs_ff;
   logic        axis_ff, axis_in, valid_ff, valid_in;

   ctl_type tilt_ctl, fuse_ctl;
   logic    tilt_done, fuse_done;
   logic signed [AngleWidth-1:0] tilt_res, fuse_res;
   logic signed [SampleWidth-1:0] sx, sy, sz, sg;

   assign sx = in_ff[15:0];
   assign sy = in_ff[31:16];
   assign sz = in_ff[47:32];
   assign sg = in_ff[63:48];

   tacf_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt (
      .clock, .reset, .ctl(tilt_ctl),
      .den(axis_ff ? sx : sy),
      .num_p(axis_ff ? sy : sx),
      .num_q(sz),
      .pos_offset(axis_ff ? apos_ff : bpos_ff),
      .neg_offset(axis_ff ? aneg_ff : bneg_ff),
      .prev(axis_ff ? ta_ff : tb_ff),
      .done(tilt_done), .tilt_out(tilt_res)
   );

   tacf_fuse u_fuse (
      .clock, .reset, .ctl(fuse_ctl),
      .angle(axis_ff ? ay_ff : ax_ff),
      .target(axis_ff ? tb_ff : ta_ff),
      .gyro(sg), .negate(!axis_ff),
      .blend_gain(gain_ff), .time_step(dt_ff), .gyro_scale(gs_ff),
      .done(fuse_done), .angle_out(fuse_res)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (st_ff == ST_IDLE) && !valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, tb_ff, ta_ff, ay_ff, ax_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         valid_ff <= 1'b0;
         ax_ff <= '0; ay_ff <= '0; ta_ff <= '0; tb_ff <= '0;
         gain_ff <= RST_BLEND_GAIN; dt_ff <= RST_TIME_STEP; gs_ff <= RST_GYRO_SCALE;
         bpos_ff <= RST_TILT_B_POS; bneg_ff <= RST_TILT_B_NEG;
         apos_ff <= RST_TILT_A_POS; aneg_ff <= RST_TILT_A_NEG;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
         if (st_ff == ST_SQRT && tilt_done) begin
            if (axis_ff) ta_ff <= tilt_res;
            else         tb_ff <= tilt_res;
         end
         if (st_ff == ST_FUSE && fuse_done) begin
            if (axis_ff) ay_ff <= fuse_res;
            else         ax_ff <= fuse_res;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BLEND_GAIN: gain_ff <= csr_data[16:0];
               CSR_TIME_STEP:  dt_ff   <= csr_data;
               CSR_GYRO_SCALE: gs_ff   <= csr_data[15:0];
               CSR_TILT_B_POS: bpos_ff <= csr_data;
               CSR_TILT_B_NEG: bneg_ff <= csr_data;
               CSR_TILT_A_POS: apos_ff <= csr_data;
               CSR_TILT_A_NEG: aneg_ff <= csr_data;
               default: ;
            endcase
         end
      end
      in_ff   <= in_in;
      axis_ff <= axis_in;
   end

   always_comb begin
      st_in    = st_ff;
      in_in    = in_ff;
      axis_in  = axis_ff;
      valid_in = valid_ff;
      tilt_ctl = '0;
      fuse_ctl = '0;
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               in_in   = req_tdata;
               axis_in = 1'b0;
               st_in   = ST_TILT;
            end
         end
         ST_TILT: begin
            tilt_ctl.start = 1'b1;
            st_in = ST_SQRT;
         end
         ST_SQRT: begin
            tilt_ctl.busy = 1'b1;
            if (tilt_done) begin
               axis_in = !axis_ff;
               st_in   = axis_ff ? ST_MUL_RATE : ST_TILT;
            end
         end
         ST_MUL_RATE: begin
            fuse_ctl.start = 1'b1;
            st_in = ST_FUSE;
         end
         ST_FUSE: begin
            fuse_ctl.busy = 1'b1;
            if (fuse_done) begin
               axis_in = !axis_ff;
               st_in   = axis_ff ? ST_DONE : ST_MUL_RATE;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            st_in    = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

endmodule

>>> src/tacf_tilt.sv
// Tilt unit: bit-serial square root followed by an iterative vectoring CORDIC.
module tacf_tilt
   import tacf_pkg::*;
#(
   parameter int CORDIC_STEPS    = DefCordicSteps
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_type                      ctl,
   input  logic signed [SampleWidth-1:0] den,
   input  logic signed [SampleWidth-1:0] num_p,
   input  logic signed [SampleWidth-1:0] num_q,
   input  logic [23:0]                  pos_offset,
   input  logic [23:0]                  neg_offset,
   input  logic signed [AngleWidth-1:0] prev,
   output logic                         done,
   output logic signed [AngleWidth-1:0] tilt_out
);

   localparam int ANGLE_FRAC_BITS = DefAngleFracBits;
   localparam int StepBits = $clog2(CORDIC_STEPS + 1);
   localparam int Sh = 24 - ANGLE_FRAC_BITS;
   localparam int DegW = 34;

   typedef enum logic [1:0] {T_IDLE, T_SQRT, T_CORD, T_END} tstate_type;

   tstate_type          st_ff, st_in;
   logic [49:0]         rad_ff, rad_in;
   logic [25:0]         root_ff, root_in;
   logic [4:0]          sq_cnt_ff, sq_cnt_in;
   logic signed [27:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0]  cz_ff, cz_in;
   logic [StepBits-1:0] step_ff, step_in;
   logic                done_ff, done_in;
   logic signed [AngleWidth-1:0] tilt_ff, tilt_in;

   logic [33:0]        psq, qsq;
   logic [51:0]        rem_try;
   logic [51:0]        rem_sh;
   logic signed [27:0] ysh, xsh;
   logic signed [DegW-1:0] zc, deg, res;
   logic [16:0]        ad;
   logic [4:0]         sidx;

   assign psq = 34'(num_p * num_p);
   assign qsq = 34'(num_q * num_q);
   assign ad  = den[SampleWidth-1] ? 17'(-18'(den)) : 17'(den);
   assign sidx = 5'(step_ff);
   assign ysh = cy_ff >>> sidx;
   assign xsh = cx_ff >>> sidx;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= T_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      sq_cnt_ff <= sq_cnt_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      step_ff   <= step_in;
      tilt_ff   <= tilt_in;
   end

   always_comb begin
      st_in     = st_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      sq_cnt_in = sq_cnt_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      step_in   = step_ff;
      tilt_in   = tilt_ff;
      done_in   = 1'b0;
      rem_sh    = '0;
      rem_try   = '0;
      zc        = '0;
      deg       = '0;
      res       = '0;
      unique case (st_ff)
         T_IDLE: begin
            if (ctl.start) begin
               rad_in    = {34'(psq + qsq), 16'd0};
               root_in   = '0;
               sq_cnt_in = 5'd25;
               st_in     = T_SQRT;
            end
         end
         T_SQRT: begin
            // One result bit per cycle, remainder kept in the low bits of cz.
            rem_sh  = {26'd0, cz_ff[25:0]};
            rem_sh  = {rem_sh[49:0], rad_ff[49:48]};
            rem_try = rem_sh - {24'd0, root_ff, 2'b01};
            rad_in  = {rad_ff[47:0], 2'b00};
            if (!rem_try[51]) begin
               cz_in   = 34'(rem_try[25:0]);
               root_in = {root_ff[24:0], 1'b1};
            end else begin
               cz_in   = 34'(rem_sh[25:0]);
               root_in = {root_ff[24:0], 1'b0};
            end
            sq_cnt_in = sq_cnt_ff - 5'd1;
            if (sq_cnt_ff == 5'd1) begin
               st_in = T_CORD;
               cx_in = 28'({ad, 8'd0});
               cy_in = 28'(root_in);
               step_in = '0;
            end
            if (sq_cnt_ff == 5'd25) begin
               rem_sh  = {50'd0, rad_ff[49:48]};
               rem_try = rem_sh - 52'd1;
               if (!rem_try[51]) begin
                  cz_in   = 34'(rem_try[25:0]);
                  root_in = 26'd1;
               end else begin
                  cz_in   = 34'(rem_sh[25:0]);
                  root_in = 26'd0;
               end
            end
         end
         T_CORD: begin
            if (step_ff == '0) begin
               cz_in = '0;
            end
            if (cy_ff > 0) begin
               cx_in = cx_ff + ysh;
               cy_in = cy_ff - xsh;
               cz_in = (step_ff == '0 ? 34'sd0 : cz_ff) + 34'(atan_q24(sidx));
            end else begin
               cx_in = cx_ff - ysh;
               cy_in = cy_ff + xsh;
               cz_in = (step_ff == '0 ? 34'sd0 : cz_ff) - 34'(atan_q24(sidx));
            end
            step_in = step_ff + 1'b1;
            if (32'(step_ff) == CORDIC_STEPS - 1 || sidx == 5'd31)
               st_in = T_END;
         end
         T_END: begin
            if (root_ff == '0) begin
               tilt_in = prev;
            end else begin
               if (ad == '0) begin
                  deg = DegW'(90) <<< ANGLE_FRAC_BITS;
               end else begin
                  zc = cz_ff;
                  if (zc < 0) zc = '0;
                  if (zc > (DegW'(90) <<< 24)) zc = DegW'(90) <<< 24;
                  if (Sh > 0) deg = (zc + (DegW'(1) <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh;
                  else deg = zc;
               end
               if (den[SampleWidth-1]) res = DegW'(neg_offset) - deg;
               else                    res = deg - DegW'(pos_offset);
               if (res > (DegW'(180) <<< ANGLE_FRAC_BITS))
                  res = DegW'(180) <<< ANGLE_FRAC_BITS;
               else if (res < -(DegW'(180) <<< ANGLE_FRAC_BITS))
                  res = -(DegW'(180) <<< ANGLE_FRAC_BITS);
               tilt_in = AngleWidth'(res);
            end
            done_in = 1'b1;
            st_in   = T_IDLE;
         end
         default: st_in = T_IDLE;
      endcase
   end

   assign done     = done_ff;
   assign tilt_out = tilt_ff;

endmodule

>>> src/tacf_fuse.sv
// Fusion unit: one shared 33x33 multiplier stepped through the blend update.
module tacf_fuse
   import tacf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  ctl_type                       ctl,
   input  logic signed [AngleWidth-1:0]  angle,
   input  logic signed [AngleWidth-1:0]  target,
   input  logic signed [SampleWidth-1:0] gyro,
   input  logic                          negate,
   input  logic [16:0]                   blend_gain,
   input  logic [23:0]                   time_step,
   input  logic [15:0]                   gyro_scale,
   output logic                          done,
   output logic signed [AngleWidth-1:0]  angle_out
);

   localparam int ANGLE_FRAC_BITS = DefAngleFracBits;

   typedef enum logic [2:0] {F_IDLE, F_RATE, F_BLEND, F_HI, F_LO, F_END} fstate_type;

   fstate_type         st_ff, st_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] hq_ff, hq_in;
   logic               done_ff, done_in;
   logic signed [AngleWidth-1:0] out_ff, out_in;

   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [63:0] h, l, sum, lim;
   logic signed [AngleWidth:0] diff;

   assign prod = ma * mb;
   assign diff = (AngleWidth+1)'(target) - (AngleWidth+1)'(angle);
   assign h    = acc_ff >>> 24;
   assign l    = acc_ff - (h <<< 24);
   assign lim  = 64'(180) <<< ANGLE_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= F_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      hq_ff  <= hq_in;
      out_ff <= out_in;
   end

   always_comb begin
      st_in   = st_ff;
      acc_in  = acc_ff;
      hq_in   = hq_ff;
      out_in  = out_ff;
      done_in = 1'b0;
      ma      = '0;
      mb      = '0;
      sum     = '0;
      unique case (st_ff)
         F_IDLE: if (ctl.start) st_in = F_RATE;
         F_RATE: begin
            ma = 33'(gyro);
            mb = 33'({1'b0, gyro_scale});
            acc_in = negate ? -(64'(prod) <<< ANGLE_FRAC_BITS)
                            :  (64'(prod) <<< ANGLE_FRAC_BITS);
            st_in = F_BLEND;
         end
         F_BLEND: begin
            ma = 33'(diff);
            mb = 33'({1'b0, blend_gain});
            acc_in = acc_ff + 64'(prod);
            st_in = F_HI;
         end
         F_HI: begin
            ma = 33'(h);
            mb = 33'({1'b0, time_step});
            hq_in = 64'(prod);
            st_in = F_LO;
         end
         F_LO: begin
            ma = 33'(l);
            mb = 33'({1'b0, time_step});
            hq_in = hq_ff + (64'(prod) >>> 24);
            st_in = F_END;
         end
         F_END: begin
            sum = 64'(angle) + ((hq_ff + 64'sd32768) >>> 16);
            if (sum > lim) sum = lim;
            else if (sum < -lim) sum = -lim;
            out_in  = AngleWidth'(sum);
            done_in = 1'b1;
            st_in   = F_IDLE;
         end
         default: st_in = F_IDLE;
      endcase
   end

   assign done      = done_ff;
   assign angle_out = out_ff;

endmodule

>>> src/tacf_checker.sv
// Port-level checker for the tilt-angle fusion block, bound to the top level.
module tacf_port_checker
   import tacf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   a_no_accept_while_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("item accepted while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[103:100] == 4'd0) else $error("pad bits set");

endmodule

bind tilt_angle_complementary_fusion tacf_port_checker u_tacf_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
